// ===== hw/rtl/mcsm_pkg.sv =====
// Shared types, codes and helper functions for the MIDI control surface mapper.
`default_nettype none

package mcsm_pkg;

  localparam int unsigned KNOB_COUNT = 8;
  localparam int unsigned PAD_COUNT  = 12;
  localparam int unsigned KNOB_AW    = $clog2(KNOB_COUNT);
  localparam int unsigned PAD_AW     = $clog2(PAD_COUNT);

  // event kinds
  localparam logic [1:0] CMD_KNOB   = 2'd0;
  localparam logic [1:0] CMD_PAD    = 2'd1;
  localparam logic [1:0] CMD_BUTTON = 2'd2;

  // operating modes
  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_MENU   = 2'd1;
  localparam logic [1:0] MODE_KNOB   = 2'd2;
  localparam logic [1:0] MODE_PAD    = 2'd3;

  // menu entries
  localparam logic [2:0] MENU_BACK  = 3'd0;
  localparam logic [2:0] MENU_KNOB  = 3'd1;
  localparam logic [2:0] MENU_PAD   = 3'd2;
  localparam logic [2:0] MENU_LOAD  = 3'd3;
  localparam logic [2:0] MENU_SAVE  = 3'd4;
  localparam logic [2:0] MENU_PANIC = 3'd5;

  // result kinds
  localparam logic [2:0] KIND_CC       = 3'd0;
  localparam logic [2:0] KIND_NOTE_ON  = 3'd1;
  localparam logic [2:0] KIND_NOTE_OFF = 3'd2;
  localparam logic [2:0] KIND_PANIC    = 3'd3;
  localparam logic [2:0] KIND_LOAD     = 3'd4;
  localparam logic [2:0] KIND_SAVE     = 3'd5;

  // pad behaviors
  localparam logic [1:0] PK_NOTE  = 2'd0;
  localparam logic [1:0] PK_CC    = 2'd1;
  localparam logic [1:0] PK_LATCH = 2'd2;

  // knob roles while editing
  localparam logic [3:0] EDIT_SEL  = 4'd0;
  localparam logic [3:0] EDIT_NUM  = 4'd1;
  localparam logic [3:0] EDIT_CHAN = 4'd2;
  localparam logic [3:0] EDIT_KIND = 4'd3;

  localparam logic [6:0] KNOB_CC_BASE = 7'd20;
  localparam logic [6:0] PAD_NUM_BASE = 7'd50;
  localparam logic [4:0] CHAN_DEFAULT = 5'd1;
  localparam logic [6:0] VEL_MAX      = 7'd127;
  localparam logic [6:0] PAD_TOUCH    = 7'd1;

  // menu band edges on knob 0
  localparam logic [6:0] MENU_T1 = 7'd20;
  localparam logic [6:0] MENU_T2 = 7'd40;
  localparam logic [6:0] MENU_T3 = 7'd60;
  localparam logic [6:0] MENU_T4 = 7'd80;
  localparam logic [6:0] MENU_T5 = 7'd100;

  // kind band edges (value / 43)
  localparam logic [6:0] KIND_T1 = 7'd43;
  localparam logic [6:0] KIND_T2 = 7'd86;

  // reciprocals, exact for 7-bit inputs with a shift of 11
  localparam logic [14:0] DIV15_MUL = 15'd137;
  localparam logic [14:0] DIV10_MUL = 15'd205;

  typedef struct packed {
    logic [6:0] cc;
    logic [4:0] chan;
  } knob_ent_t;

  typedef struct packed {
    logic [6:0] number;
    logic [4:0] chan;
    logic [1:0] kind;
  } pad_ent_t;

  function automatic logic [3:0] div15(input logic [6:0] v);
    logic [14:0] p;
    p = {8'd0, v} * DIV15_MUL;
    return p[14:11];
  endfunction

  function automatic logic [3:0] div10(input logic [6:0] v);
    logic [14:0] p;
    p = {8'd0, v} * DIV10_MUL;
    return p[14:11];
  endfunction

  function automatic logic [1:0] div43(input logic [6:0] v);
    logic [1:0] k;
    if (v >= KIND_T2) k = 2'd2;
    else if (v >= KIND_T1) k = 2'd1;
    else k = 2'd0;
    return k;
  endfunction

  function automatic knob_ent_t knob_reset(input logic [KNOB_AW-1:0] a);
    knob_ent_t e;
    e.cc   = KNOB_CC_BASE + 7'(a);
    e.chan = CHAN_DEFAULT;
    return e;
  endfunction

  function automatic pad_ent_t pad_reset(input logic [PAD_AW-1:0] a);
    pad_ent_t e;
    e.number = PAD_NUM_BASE + 7'(a);
    e.chan   = CHAN_DEFAULT;
    e.kind   = PK_NOTE;
    return e;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/midi_control_surface_mapper.sv =====
// Top level: knob/pad/button events to MIDI messages and setup-menu requests.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------------
//  in_     | input     | in_valid / in_stall  | in_cmd, in_id, in_value
//  out_    | output    | out_valid / out_stall| out_emit, out_kind, out_number, out_amount,
//          |           |                      | out_channel, out_mode
//
// Cycles: one request per clock while out_stall is low; every request yields exactly one
//   result, held in s1 and then in the output register. The rate is set by the single
//   read-modify-write pass through the knob and pad table RAMs (one read port each).
// Reset: rst_n (sync, low) clears mode, menu, edit buffers, latch bits and the table
//   valid bits; an entry never written reads as its default mapping. No clearing pass.
// Stalls: out_stall holds the output register; with a result also waiting in the
//   lookup stage, in_stall rises until the output register frees.
`default_nettype none

module midi_control_surface_mapper
  import mcsm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,

  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_cmd,
  input  wire logic [3:0] in_id,
  input  wire logic [6:0] in_value,

  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_emit,
  output logic      [2:0] out_kind,
  output logic      [6:0] out_number,
  output logic      [6:0] out_amount,
  output logic      [4:0] out_channel,
  output logic      [1:0] out_mode
);

  // ---------------------------------------------------------------------------
  // Control state (registers) and their next values
  // ---------------------------------------------------------------------------
  logic [1:0]           mode_r,  mode_nxt;
  logic [2:0]           menu_r,  menu_nxt;
  logic [3:0]           eki_r,   eki_nxt;     // edit knob index, 8 = exit
  logic [6:0]           ekc_r,   ekc_nxt;
  logic [4:0]           ekch_r,  ekch_nxt;
  logic [3:0]           epi_r,   epi_nxt;     // edit pad index, 12 = exit
  logic [6:0]           epn_r,   epn_nxt;
  logic [4:0]           epch_r,  epch_nxt;
  logic [1:0]           epk_r,   epk_nxt;
  logic [PAD_COUNT-1:0] latch_r, latch_nxt;
  logic [KNOB_COUNT-1:0] knob_vld_r;
  logic [PAD_COUNT-1:0]  pad_vld_r;

  // ---------------------------------------------------------------------------
  // Lookup stage (s1): request waiting on RAM read data
  // ---------------------------------------------------------------------------
  logic              s1_vld_r;
  logic [1:0]        s1_cmd_r;
  logic [3:0]        s1_id_r;
  logic [6:0]        s1_val_r;
  logic [KNOB_AW-1:0] s1_kaddr_r;
  logic [PAD_AW-1:0]  s1_paddr_r;
  logic              s1_kvld_r, s1_pvld_r;
  logic              s1_kfwd_r, s1_pfwd_r;
  knob_ent_t         s1_kfwd_data_r;
  pad_ent_t          s1_pfwd_data_r;

  logic in_acc, s1_adv, s1_fire;

  // output register
  logic       out_valid_r;
  logic       out_emit_r;
  logic [2:0] out_kind_r;
  logic [6:0] out_number_r, out_amount_r;
  logic [4:0] out_channel_r;
  logic [1:0] out_mode_r;

  // result computed in s1
  logic       res_emit;
  logic [2:0] res_kind;
  logic [6:0] res_number, res_amount;
  logic [4:0] res_channel;

  // RAM ports
  logic               k_we, k_re, p_we, p_re;
  logic [KNOB_AW-1:0] k_waddr, k_raddr;
  logic [PAD_AW-1:0]  p_waddr, p_raddr;
  knob_ent_t          k_wdata, k_rdata, k_ent;
  pad_ent_t           p_wdata, p_rdata, p_ent;
  logic               k_vld_rd, p_vld_rd, p_raddr_ok;
  logic [3:0]         k_sel_idx;

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  assign s1_adv   = !out_valid_r || !out_stall;
  assign s1_fire  = s1_vld_r && s1_adv;
  assign in_stall = s1_vld_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  // ---------------------------------------------------------------------------
  // Table RAMs
  // ---------------------------------------------------------------------------
  mcsm_ram #(
    .WIDTH ($bits(knob_ent_t)),
    .DEPTH (KNOB_COUNT)
  ) u_knob_ram (
    .clk   (clk),
    .we    (k_we),
    .waddr (k_waddr),
    .wdata (k_wdata),
    .re    (k_re),
    .raddr (k_raddr),
    .rdata (k_rdata)
  );

  mcsm_ram #(
    .WIDTH ($bits(pad_ent_t)),
    .DEPTH (PAD_COUNT)
  ) u_pad_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .re    (p_re),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  assign k_sel_idx = div15(in_value);

  // Read address is picked at accept time from the control state the previous
  // request leaves behind (the _nxt values), so back-to-back requests see it.
  always_comb begin
    k_raddr = in_id[KNOB_AW-1:0];
    p_raddr = in_id;
    if (in_cmd == CMD_BUTTON) begin
      k_raddr = eki_nxt[KNOB_AW-1:0];            // knob-setup entry reload
    end else if (in_cmd == CMD_KNOB && in_id == EDIT_SEL) begin
      if (mode_nxt == MODE_KNOB) begin
        k_raddr = k_sel_idx[KNOB_AW-1:0];
      end
      if (mode_nxt == MODE_PAD) begin
        p_raddr = div10(in_value);
      end
    end
  end

  assign p_raddr_ok = p_raddr < PAD_AW'(PAD_COUNT);
  assign k_re       = in_acc;
  assign p_re       = in_acc && p_raddr_ok;
  assign k_vld_rd   = knob_vld_r[k_raddr];
  assign p_vld_rd   = p_raddr_ok ? pad_vld_r[p_raddr] : 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_acc || (s1_vld_r && !s1_adv);
    end
  end

  // A commit in the same cycle as the read of that entry is forwarded.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r       <= in_cmd;
      s1_id_r        <= in_id;
      s1_val_r       <= in_value;
      s1_kaddr_r     <= k_raddr;
      s1_paddr_r     <= p_raddr;
      s1_kvld_r      <= k_vld_rd;
      s1_pvld_r      <= p_vld_rd;
      s1_kfwd_r      <= k_we && (k_waddr == k_raddr);
      s1_pfwd_r      <= p_we && (p_waddr == p_raddr);
      s1_kfwd_data_r <= k_wdata;
      s1_pfwd_data_r <= p_wdata;
    end
  end

  // Entries never written read as their default mapping.
  always_comb begin
    if (s1_kfwd_r)      k_ent = s1_kfwd_data_r;
    else if (s1_kvld_r) k_ent = k_rdata;
    else                k_ent = knob_reset(s1_kaddr_r);
    if (s1_pfwd_r)      p_ent = s1_pfwd_data_r;
    else if (s1_pvld_r) p_ent = p_rdata;
    else                p_ent = pad_reset(s1_paddr_r);
  end

  // ---------------------------------------------------------------------------
  // Event processing in s1: result, state update, table writes
  // ---------------------------------------------------------------------------
  always_comb begin
    mode_nxt  = mode_r;
    menu_nxt  = menu_r;
    eki_nxt   = eki_r;
    ekc_nxt   = ekc_r;
    ekch_nxt  = ekch_r;
    epi_nxt   = epi_r;
    epn_nxt   = epn_r;
    epch_nxt  = epch_r;
    epk_nxt   = epk_r;
    latch_nxt = latch_r;

    res_emit    = 1'b0;
    res_kind    = KIND_CC;
    res_number  = '0;
    res_amount  = '0;
    res_channel = CHAN_DEFAULT;

    k_we    = 1'b0;
    k_waddr = eki_r[KNOB_AW-1:0];
    k_wdata = '{cc: ekc_r, chan: ekch_r};
    p_we    = 1'b0;
    p_waddr = epi_r;
    p_wdata = '{number: epn_r, chan: epch_r, kind: epk_r};

    if (s1_fire) begin
      case (s1_cmd_r)
        CMD_KNOB: begin
          unique case (mode_r)
            MODE_NORMAL: begin
              if (s1_id_r < 4'(KNOB_COUNT)) begin
                res_emit    = 1'b1;
                res_kind    = KIND_CC;
                res_number  = k_ent.cc;
                res_amount  = s1_val_r;
                res_channel = k_ent.chan;
              end
            end
            MODE_MENU: begin
              if (s1_id_r == EDIT_SEL) begin
                if (s1_val_r < MENU_T1)      menu_nxt = MENU_BACK;
                else if (s1_val_r < MENU_T2) menu_nxt = MENU_KNOB;
                else if (s1_val_r < MENU_T3) menu_nxt = MENU_PAD;
                else if (s1_val_r < MENU_T4) menu_nxt = MENU_LOAD;
                else if (s1_val_r < MENU_T5) menu_nxt = MENU_SAVE;
                else                         menu_nxt = MENU_PANIC;
              end
            end
            MODE_KNOB: begin
              if (s1_id_r == EDIT_SEL) begin
                eki_nxt = div15(s1_val_r);
                if (eki_nxt < 4'(KNOB_COUNT)) begin
                  ekc_nxt  = k_ent.cc;
                  ekch_nxt = k_ent.chan;
                end
              end else if (s1_id_r == EDIT_NUM) begin
                ekc_nxt = s1_val_r;
              end else if (s1_id_r == EDIT_CHAN) begin
                ekch_nxt = 5'(s1_val_r[6:3]) + CHAN_DEFAULT;
              end
            end
            MODE_PAD: begin
              if (s1_id_r == EDIT_SEL) begin
                epi_nxt = div10(s1_val_r);
                if (epi_nxt < 4'(PAD_COUNT)) begin
                  epn_nxt  = p_ent.number;
                  epch_nxt = p_ent.chan;
                  epk_nxt  = p_ent.kind;
                end
              end else if (s1_id_r == EDIT_NUM) begin
                epn_nxt = s1_val_r;
              end else if (s1_id_r == EDIT_CHAN) begin
                epch_nxt = 5'(s1_val_r[6:3]) + CHAN_DEFAULT;
              end else if (s1_id_r == EDIT_KIND) begin
                epk_nxt = div43(s1_val_r);
              end
            end
            default: ;
          endcase
        end

        CMD_PAD: begin
          if (s1_id_r < 4'(PAD_COUNT)) begin
            case (p_ent.kind)
              PK_NOTE: begin
                res_emit    = 1'b1;
                res_number  = p_ent.number;
                res_channel = p_ent.chan;
                if (s1_val_r == PAD_TOUCH) begin
                  res_kind   = KIND_NOTE_ON;
                  res_amount = VEL_MAX;
                end else begin
                  res_kind   = KIND_NOTE_OFF;
                end
              end
              PK_CC: begin
                res_emit    = 1'b1;
                res_kind    = KIND_CC;
                res_number  = p_ent.number;
                res_channel = p_ent.chan;
                res_amount  = (s1_val_r == PAD_TOUCH) ? VEL_MAX : 7'd0;
              end
              PK_LATCH: begin
                if (s1_val_r == PAD_TOUCH) begin
                  latch_nxt[s1_id_r] = !latch_r[s1_id_r];
                  res_emit    = 1'b1;
                  res_kind    = KIND_CC;
                  res_number  = p_ent.number;
                  res_channel = p_ent.chan;
                  res_amount  = latch_nxt[s1_id_r] ? VEL_MAX : 7'd0;
                end
              end
              default: ;   // unused pad kind sends nothing
            endcase
          end
        end

        CMD_BUTTON: begin
          if (s1_val_r != 7'd0) begin
            unique case (mode_r)
              MODE_NORMAL: mode_nxt = MODE_MENU;
              MODE_MENU: begin
                mode_nxt = MODE_NORMAL;
                unique case (menu_r)
                  MENU_KNOB: begin
                    mode_nxt = MODE_KNOB;
                    if (eki_r < 4'(KNOB_COUNT)) begin
                      ekc_nxt  = k_ent.cc;
                      ekch_nxt = k_ent.chan;
                    end
                  end
                  MENU_PAD: mode_nxt = MODE_PAD;
                  MENU_LOAD: begin
                    res_emit = 1'b1;
                    res_kind = KIND_LOAD;
                  end
                  MENU_SAVE: begin
                    res_emit = 1'b1;
                    res_kind = KIND_SAVE;
                  end
                  MENU_PANIC: begin
                    res_emit = 1'b1;
                    res_kind = KIND_PANIC;
                  end
                  default: ;   // back, or an unreachable choice
                endcase
              end
              MODE_KNOB: begin
                if (eki_r < 4'(KNOB_COUNT)) k_we = 1'b1;
                else mode_nxt = MODE_NORMAL;
              end
              MODE_PAD: begin
                if (epi_r < 4'(PAD_COUNT)) p_we = 1'b1;
                else mode_nxt = MODE_NORMAL;
              end
              default: ;
            endcase
          end
        end

        default: ;   // unused command
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // State registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_NORMAL;
      menu_r     <= MENU_BACK;
      eki_r      <= '0;
      ekc_r      <= '0;
      ekch_r     <= CHAN_DEFAULT;
      epi_r      <= '0;
      epn_r      <= '0;
      epch_r     <= CHAN_DEFAULT;
      epk_r      <= PK_NOTE;
      latch_r    <= '0;
      knob_vld_r <= '0;
      pad_vld_r  <= '0;
    end else begin
      mode_r  <= mode_nxt;
      menu_r  <= menu_nxt;
      eki_r   <= eki_nxt;
      ekc_r   <= ekc_nxt;
      ekch_r  <= ekch_nxt;
      epi_r   <= epi_nxt;
      epn_r   <= epn_nxt;
      epch_r  <= epch_nxt;
      epk_r   <= epk_nxt;
      latch_r <= latch_nxt;
      if (k_we) knob_vld_r[k_waddr] <= 1'b1;
      if (p_we) pad_vld_r[p_waddr]  <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_fire || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_emit_r    <= res_emit;
      out_kind_r    <= res_kind;
      out_number_r  <= res_number;
      out_amount_r  <= res_amount;
      out_channel_r <= res_channel;
      out_mode_r    <= mode_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_emit    = out_emit_r;
  assign out_kind    = out_kind_r;
  assign out_number  = out_number_r;
  assign out_amount  = out_amount_r;
  assign out_channel = out_channel_r;
  assign out_mode    = out_mode_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_channel_r != 5'd0) && (out_channel_r <= 5'd16))
    else $error("output channel outside 1..16");

  a_req_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_emit_r && (out_kind_r == KIND_PANIC || out_kind_r == KIND_LOAD
      || out_kind_r == KIND_SAVE))
    |-> (out_number_r == 7'd0) && (out_amount_r == 7'd0) && (out_mode_r == MODE_NORMAL))
    else $error("request result with stray fields or mode");

  a_commit_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (k_we || p_we) |-> !(k_we && p_we) && (mode_nxt == mode_r)
      && (mode_r == MODE_KNOB || mode_r == MODE_PAD))
    else $error("table commit outside a setup mode");

  a_fire_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r && (out_mode_r == $past(mode_nxt)))
    else $error("lookup stage fired without a result");

endmodule

`default_nettype wire

// ===== hw/rtl/mcsm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mcsm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire
